// ===== rtl/led_strip_spi_frame_encoder_assert.svh =====
// Assertion macros shared by the checker.
`ifndef LED_STRIP_SPI_FRAME_ENCODER_ASSERT_SVH
`define LED_STRIP_SPI_FRAME_ENCODER_ASSERT_SVH

// same-cycle implication
`define LSSFE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LSSFE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lssfe_pkg.sv =====
`default_nettype none

package lssfe_pkg;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_FILL  = 2'd1,
      CMD_START = 2'd2,
      CMD_TICK  = 2'd3
   } cmd_type;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_RANGE    = 2'd1;
   localparam logic [1:0] STATUS_NO_FRAME = 2'd2;

   localparam logic [1:0] REG_PIXEL_COUNT = 2'd0;
   localparam logic [1:0] REG_GRB_ORDER   = 2'd1;
   localparam logic [1:0] REG_LEAD_ZERO   = 2'd2;
   localparam logic [1:0] REG_TAIL_ZERO   = 2'd3;

   localparam logic [7:0] TAIL_ZERO_RESET = 8'd64;

   localparam logic [7:0] SPI_PAIR_0 = 8'b10001000;
   localparam logic [7:0] SPI_PAIR_1 = 8'b10001110;
   localparam logic [7:0] SPI_PAIR_2 = 8'b11101000;
   localparam logic [7:0] SPI_PAIR_3 = 8'b11101110;

   // x/3 as (x * 683) >> 11, exact for x below 2048
   localparam logic [9:0] DIV3_RECIP = 10'd683;

   typedef struct packed {
      cmd_type     cmd;
      logic        in_range;
      logic [7:0]  index;
      logic [23:0] color;
   } op_type;

   typedef struct packed {
      logic [7:0] spi_byte;
      logic       byte_valid;
      logic       last_byte;
      logic [1:0] status;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_FILL_DONE,
      ST_TICK_DIV,
      ST_TICK_READ,
      ST_TICK_EMIT
   } back_state_type;

   function automatic logic [7:0] pair_code(input logic [1:0] pair);
      logic [7:0] code;
      case (pair)
         2'd0: code = SPI_PAIR_0;
         2'd1: code = SPI_PAIR_1;
         2'd2: code = SPI_PAIR_2;
         default: code = SPI_PAIR_3;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/lssfe_front.sv =====
`default_nettype none

module lssfe_front
   import lssfe_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [1:0] req_cmd,
   input  wire logic [7:0] req_pixel_index,
   input  wire logic [7:0] req_red,
   input  wire logic [7:0] req_green,
   input  wire logic [7:0] req_blue,
   input  wire logic [7:0] active_count,
   output logic            op_valid,
   output op_type          op,
   input  wire logic       op_pop
);

   op_type     queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       accept;
   logic       take;
   op_type     new_op;

   assign req_full = (count_ff == 2'd2);
   assign op_valid = (count_ff != 2'd0);
   assign op       = queue_ff[rd_ptr_ff];
   assign accept   = req_push && !req_full;
   assign take     = op_pop && op_valid;

   always_comb begin
      new_op.cmd      = cmd_type'(req_cmd);
      new_op.in_range = (req_pixel_index < active_count);
      new_op.index    = req_pixel_index;
      new_op.color    = {req_red, req_green, req_blue};
   end

   always_comb begin
      wr_ptr_in = accept ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, accept} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= new_op;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lssfe_back.sv =====
`default_nettype none

module lssfe_back
   import lssfe_pkg::*;
#(
   parameter int STORE_DEPTH = 256
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       op_valid,
   input  wire op_type     op,
   output logic            op_pop,
   input  wire logic [7:0] active_count,
   input  wire logic       grb_order,
   input  wire logic [7:0] lead_zero_bytes,
   input  wire logic [7:0] tail_zero_bytes,
   input  wire logic       res_full,
   output logic            res_push,
   output result_type      res
);

   localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   back_state_type state_ff, state_in;

   logic [23:0]            store_mem [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] store_valid_ff;

   logic        frame_active_ff, frame_active_in;
   logic [11:0] frame_pos_ff, frame_pos_in;
   logic [7:0]  fill_cnt_ff, fill_cnt_in;
   logic        zero_ff, zero_in;
   logic        last_ff, last_in;
   logic [11:0] q_ff, q_in;
   logic [7:0]  pix_ff, pix_in;
   logic [3:0]  k_ff, k_in;
   logic [23:0] rd_data_ff;
   logic        rd_valid_ff;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [AW-1:0] mem_raddr;

   logic [11:0] body_len;
   logic [11:0] frame_len;
   logic        tick_ok;
   logic        tick_last;
   logic [11:0] q_now;
   logic        zero_now;
   logic [19:0] div_prod;
   logic [11:0] pix_x12;
   logic [23:0] color;
   logic [7:0]  color_byte;
   logic [1:0]  pair;

   assign body_len  = {1'b0, active_count, 3'b000} + {2'b00, active_count, 2'b00};
   assign frame_len = {4'd0, lead_zero_bytes} + body_len + {4'd0, tail_zero_bytes};
   assign tick_ok   = frame_active_ff && (frame_pos_ff < frame_len);
   assign tick_last = ((frame_pos_ff + 12'd1) == frame_len);
   assign q_now     = frame_pos_ff - {4'd0, lead_zero_bytes};
   assign zero_now  = (frame_pos_ff < {4'd0, lead_zero_bytes}) || (q_now >= body_len);

   assign div_prod  = {10'd0, q_ff[11:2]} * {10'd0, DIV3_RECIP};
   assign pix_x12   = {1'b0, pix_ff, 3'b000} + {2'b00, pix_ff, 2'b00};
   assign mem_raddr = pix_ff[AW-1:0];

   always_comb begin
      color = rd_valid_ff ? rd_data_ff : 24'd0;
      case (k_ff[3:2])
         2'd0: color_byte = grb_order ? color[15:8] : color[23:16];
         2'd1: color_byte = grb_order ? color[23:16] : color[15:8];
         default: color_byte = color[7:0];
      endcase
      case (k_ff[1:0])
         2'd0: pair = color_byte[7:6];
         2'd1: pair = color_byte[5:4];
         2'd2: pair = color_byte[3:2];
         default: pair = color_byte[1:0];
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (op_valid) begin
               if (op.cmd == CMD_FILL && active_count != 8'd0) begin
                  state_in = ST_FILL;
               end else if (op.cmd == CMD_TICK && tick_ok) begin
                  state_in = zero_now ? ST_TICK_EMIT : ST_TICK_DIV;
               end
            end
         end
         ST_FILL: begin
            if (fill_cnt_ff == active_count - 8'd1) begin
               state_in = ST_FILL_DONE;
            end
         end
         ST_FILL_DONE: begin
            if (!res_full) begin
               state_in = ST_IDLE;
            end
         end
         ST_TICK_DIV: state_in = ST_TICK_READ;
         ST_TICK_READ: state_in = ST_TICK_EMIT;
         ST_TICK_EMIT: begin
            if (!res_full) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      op_pop         = 1'b0;
      res_push       = 1'b0;
      res.spi_byte   = 8'd0;
      res.byte_valid = 1'b0;
      res.last_byte  = 1'b0;
      res.status     = STATUS_OK;
      mem_we         = 1'b0;
      mem_waddr      = op.index[AW-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (op_valid && !res_full) begin
               case (op.cmd)
                  CMD_WRITE: begin
                     op_pop     = 1'b1;
                     res_push   = 1'b1;
                     mem_we     = op.in_range;
                     res.status = op.in_range ? STATUS_OK : STATUS_RANGE;
                  end
                  CMD_FILL: begin
                     op_pop   = (active_count == 8'd0);
                     res_push = (active_count == 8'd0);
                  end
                  CMD_START: begin
                     op_pop   = 1'b1;
                     res_push = 1'b1;
                  end
                  default: begin
                     op_pop     = !tick_ok;
                     res_push   = !tick_ok;
                     res.status = STATUS_NO_FRAME;
                  end
               endcase
            end
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = fill_cnt_ff[AW-1:0];
         end
         ST_FILL_DONE: begin
            op_pop   = !res_full;
            res_push = !res_full;
         end
         ST_TICK_EMIT: begin
            op_pop         = !res_full;
            res_push       = !res_full;
            res.spi_byte   = zero_ff ? 8'd0 : pair_code(pair);
            res.byte_valid = 1'b1;
            res.last_byte  = last_ff;
         end
         default: begin
            op_pop = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      frame_active_in = frame_active_ff;
      frame_pos_in    = frame_pos_ff;
      fill_cnt_in     = fill_cnt_ff;
      zero_in         = zero_ff;
      last_in         = last_ff;
      q_in            = q_ff;
      pix_in          = pix_ff;
      k_in            = k_ff;
      case (state_ff)
         ST_IDLE: begin
            fill_cnt_in = 8'd0;
            if (op_valid && op.cmd == CMD_START && !res_full) begin
               frame_active_in = (active_count != 8'd0);
               frame_pos_in    = 12'd0;
            end else if (op_valid && op.cmd == CMD_TICK) begin
               zero_in = zero_now;
               last_in = tick_last;
               q_in    = q_now;
               if (!tick_ok) begin
                  if (!res_full) begin
                     frame_active_in = 1'b0;
                     frame_pos_in    = 12'd0;
                  end
               end else if (tick_last) begin
                  frame_active_in = 1'b0;
                  frame_pos_in    = 12'd0;
               end else begin
                  frame_pos_in = frame_pos_ff + 12'd1;
               end
            end
         end
         ST_FILL: fill_cnt_in = fill_cnt_ff + 8'd1;
         ST_TICK_DIV: pix_in = div_prod[18:11];
         ST_TICK_READ: k_in = 4'(q_ff - pix_x12);
         default: begin
            fill_cnt_in = fill_cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         frame_active_ff <= 1'b0;
         frame_pos_ff    <= 12'd0;
         fill_cnt_ff     <= 8'd0;
      end else begin
         state_ff        <= state_in;
         frame_active_ff <= frame_active_in;
         frame_pos_ff    <= frame_pos_in;
         fill_cnt_ff     <= fill_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      zero_ff <= zero_in;
      last_ff <= last_in;
      q_ff    <= q_in;
      pix_ff  <= pix_in;
      k_ff    <= k_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= op.color;
      end
      if (state_ff == ST_TICK_READ) begin
         rd_data_ff  <= store_mem[mem_raddr];
         rd_valid_ff <= store_valid_ff[mem_raddr];
      end
   end

   // unwritten entries read as black
   always_ff @(posedge clock) begin
      if (reset) begin
         store_valid_ff <= '0;
      end else if (mem_we) begin
         store_valid_ff[mem_waddr] <= 1'b1;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lssfe_rsp_queue.sv =====
`default_nettype none

module lssfe_rsp_queue
   import lssfe_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       res_push,
   input  wire result_type res,
   output logic            res_full,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output result_type      rsp_data
);

   result_type queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       put;
   logic       take;

   assign res_full  = (count_ff == 2'd2);
   assign rsp_empty = (count_ff == 2'd0);
   assign rsp_data  = queue_ff[rd_ptr_ff];
   assign put       = res_push && !res_full;
   assign take      = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = put ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, put} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (put) begin
         queue_ff[wr_ptr_ff] <= res;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/led_strip_spi_frame_encoder.sv =====
// LED strip SPI frame encoder.
// Requests come in on a queue port (req_push / req_full) and each one gives
// exactly one response on a queue port (rsp_empty / rsp_pop), in order.
// Commands: write one pixel, fill all active pixels, start a frame or tick out
// the next encoded SPI byte. The user must write registers through csr_we /
// csr_index / csr_wdata while no request is in flight; the block does not enforce it.
// A front stage classifies requests into a 2-entry command queue; a back
// sequencer runs them against a single-port pixel store and pushes into a
// 2-entry response queue, so either side may stall without losing data.
// A write, a start or a tick with no frame is answered from the sequencer's idle
// state; a lead or tail zero byte passes from idle to encode, a pixel byte goes
// through divide, store read and encode, and a fill makes one store write per
// active pixel and then answers. Throughput: one write or start per cycle while
// the response queue has room; the sequencer finishes each tick or fill before
// it takes the next command.
// When rsp_pop is held low the response queue fills, the sequencer halts and
// req_full rises once the command queue is full.
// Reset empties both queues, stops any frame, restores register defaults
// and marks the pixel store black in the same cycle.
`default_nettype none

module led_strip_spi_frame_encoder
   import lssfe_pkg::*;
#(
   parameter int MAX_PIXELS = 256
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [1:0] req_cmd,
   input  wire logic [7:0] req_pixel_index,
   input  wire logic [7:0] req_red,
   input  wire logic [7:0] req_green,
   input  wire logic [7:0] req_blue,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_spi_byte,
   output logic            rsp_byte_valid,
   output logic            rsp_last_byte,
   output logic [1:0]      rsp_status,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata
);

   localparam int STORE_DEPTH = (MAX_PIXELS < 256) ? MAX_PIXELS : 256;

   logic [7:0] pixel_count_ff;
   logic       grb_order_ff;
   logic [7:0] lead_zero_ff;
   logic [7:0] tail_zero_ff;
   logic [7:0] active_count;

   logic       op_valid;
   op_type     op;
   logic       op_pop;
   logic       res_full;
   logic       res_push;
   result_type res;
   result_type rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff <= 8'd0;
         grb_order_ff   <= 1'b0;
         lead_zero_ff   <= 8'd0;
         tail_zero_ff   <= TAIL_ZERO_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_PIXEL_COUNT: pixel_count_ff <= csr_wdata;
            REG_GRB_ORDER: grb_order_ff <= csr_wdata[0];
            REG_LEAD_ZERO: lead_zero_ff <= csr_wdata;
            REG_TAIL_ZERO: tail_zero_ff <= csr_wdata;
            default: tail_zero_ff <= tail_zero_ff;
         endcase
      end
   end

   assign active_count = ({1'b0, pixel_count_ff} < 9'(STORE_DEPTH)) ?
                         pixel_count_ff : 8'(STORE_DEPTH);

   lssfe_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_cmd         (req_cmd),
      .req_pixel_index (req_pixel_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .active_count    (active_count),
      .op_valid        (op_valid),
      .op              (op),
      .op_pop          (op_pop)
   );

   lssfe_back #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .op_valid        (op_valid),
      .op              (op),
      .op_pop          (op_pop),
      .active_count    (active_count),
      .grb_order       (grb_order_ff),
      .lead_zero_bytes (lead_zero_ff),
      .tail_zero_bytes (tail_zero_ff),
      .res_full        (res_full),
      .res_push        (res_push),
      .res             (res)
   );

   lssfe_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .res_push  (res_push),
      .res       (res),
      .res_full  (res_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   assign rsp_spi_byte   = rsp_data.spi_byte;
   assign rsp_byte_valid = rsp_data.byte_valid;
   assign rsp_last_byte  = rsp_data.last_byte;
   assign rsp_status     = rsp_data.status;

endmodule

`default_nettype wire

// ===== rtl/lssfe_checker.sv =====
`default_nettype none

`include "led_strip_spi_frame_encoder_assert.svh"

module lssfe_checker
   import lssfe_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       rsp_empty,
   input  wire logic       rsp_pop,
   input  wire logic [7:0] rsp_spi_byte,
   input  wire logic       rsp_byte_valid,
   input  wire logic       rsp_last_byte,
   input  wire logic [1:0] rsp_status
);

   `LSSFE_ASSERT_NOW(a_valid_is_ok, clock, reset, !rsp_empty && rsp_byte_valid, rsp_status == STATUS_OK, "frame byte with error status")
   `LSSFE_ASSERT_NOW(a_last_has_byte, clock, reset, !rsp_empty && rsp_last_byte, rsp_byte_valid, "last flag without a frame byte")
   `LSSFE_ASSERT_NOW(a_idle_byte_zero, clock, reset, !rsp_empty && !rsp_byte_valid, rsp_spi_byte == 8'd0, "non-zero byte on a non-byte response")
   `LSSFE_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_spi_byte) && $stable(rsp_status), "stalled response changed")

endmodule

bind led_strip_spi_frame_encoder lssfe_checker u_checker (.*);

`default_nettype wire
